// ===== hdl/fptd_pkg.sv =====
// Shared constants, codes and control types of the fixed-priority task dispatcher.
`timescale 1ns / 1ps

package fptd_pkg;

    localparam int TASKS       = 8;
    localparam int TASK_IDX_W  = $clog2(TASKS);
    localparam int TASK_CNT_W  = 4;
    localparam int PRIO_W      = 3;
    localparam int PRIO_BITS   = PRIO_W * TASKS;
    localparam int STAT_W      = 32;
    localparam int LOAD_W      = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;

    localparam int TOP_PRIORITY = 5;
    localparam int IDLE_CAP     = 5000;
    localparam int FULL_PERCENT = 100;

    // Width of a clamped idle-run difference (0..IDLE_CAP).
    localparam int DIFF_W = $clog2(IDLE_CAP + 1);
    // Reciprocal of IDLE_CAP / FULL_PERCENT (= 50), scaled by 2^RECIP_SHIFT.
    // For some values up to IDLE_CAP (such as 4999) the rounded-up reciprocal gives one more than the exact floor.
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = 11;
    localparam int RECIP       = ((1 << RECIP_SHIFT) * FULL_PERCENT + IDLE_CAP - 1) / IDLE_CAP;
    localparam int PROD_W      = DIFF_W + RECIP_W;

    typedef enum logic [2:0] {
        CMD_SCAN    = 3'd0,
        CMD_DISABLE = 3'd1,
        CMD_ENABLE  = 3'd2,
        CMD_SUSPEND = 3'd3,
        CMD_RESUME  = 3'd4,
        CMD_REPORT  = 3'd5,
        CMD_LOAD    = 3'd6,
        CMD_STATS   = 3'd7
    } cmd_t;

    localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIORITIES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TASK  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // take the input word
        logic prep;      // first step of a load update
        logic emit;      // produce one result word
    } dp_ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;  // output register can take a word this cycle
        logic final_res; // the word produced now is the last of the item
    } dp_stat_t;

endpackage

// ===== hdl/fptd_ctrl.sv =====
// Controller state machine of the fixed-priority task dispatcher.
`timescale 1ns / 1ps

module fptd_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  fptd_pkg::dp_stat_t stat,
    output fptd_pkg::dp_ctrl_t ctrl
);
    import fptd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_PREP = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        ctrl.capture = 1'b0;
        ctrl.prep    = 1'b0;
        ctrl.emit    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.capture = 1'b1;
                    state_next   = ST_PREP;
                end
            end
            ST_PREP:
            begin
                ctrl.prep  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    ctrl.emit = 1'b1;
                    if (stat.final_res)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/fptd_dp.sv =====
// Datapath of the fixed-priority task dispatcher: registers, task tables and result register.
`timescale 1ns / 1ps

module fptd_dp
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  fptd_pkg::dp_ctrl_t                   ctrl,
    output fptd_pkg::dp_stat_t                   stat,
    input  logic                                 cfg_write_en,
    input  logic [fptd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fptd_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [2:0]                           command,
    input  logic [3:0]                           task_id,
    input  logic [fptd_pkg::TASKS-1:0]           expired_mask,
    input  logic [fptd_pkg::STAT_W-1:0]          exec_cycles,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 dispatch_valid,
    output logic [fptd_pkg::TASK_IDX_W-1:0]      task_index,
    output logic                                 last,
    output logic                                 status,
    output logic [fptd_pkg::STAT_W-1:0]          run_count,
    output logic [fptd_pkg::STAT_W-1:0]          total_cycles,
    output logic [fptd_pkg::STAT_W-1:0]          max_cycles,
    output logic [fptd_pkg::LOAD_W-1:0]          cpu_load
);
    import fptd_pkg::*;

    // Configuration registers.
    logic [TASK_CNT_W-1:0] task_count_reg;
    logic [PRIO_BITS-1:0]  task_prio_reg;
    logic [TASK_CNT_W-1:0] idle_task_reg;

    // Task tables and load state.
    logic [TASKS-1:0]  enabled_reg,   enabled_next;
    logic [TASKS-1:0]  suspended_reg, suspended_next;
    logic [STAT_W-1:0] runs_reg  [TASKS];
    logic [STAT_W-1:0] runs_next [TASKS];
    logic [STAT_W-1:0] sums_reg  [TASKS];
    logic [STAT_W-1:0] sums_next [TASKS];
    logic [STAT_W-1:0] maxs_reg  [TASKS];
    logic [STAT_W-1:0] maxs_next [TASKS];
    logic [STAT_W-1:0] prev_idle_reg, prev_idle_next;
    logic [LOAD_W-1:0] load_reg,      load_next;

    // Captured input word.
    cmd_t              op_reg,      op_next;
    logic [3:0]        id_reg,      id_next;
    logic [STAT_W-1:0] cycles_reg,  cycles_next;
    logic [TASKS-1:0]  pending_reg, pending_next;
    logic [DIFF_W-1:0] diff_reg,    diff_next;

    // Result register.
    logic                  out_valid_reg, out_valid_next;
    logic                  dv_reg,    dv_next;
    logic [TASK_IDX_W-1:0] idx_reg,   idx_next;
    logic                  last_reg,  last_next;
    logic                  stat_reg,  stat_next;
    logic [STAT_W-1:0]     run_reg,   run_next;
    logic [STAT_W-1:0]     tot_reg,   tot_next;
    logic [STAT_W-1:0]     max_reg,   max_next;
    logic [LOAD_W-1:0]     load_o_reg, load_o_next;

    // Combinational helpers.
    logic [TASK_CNT_W-1:0] count_live;
    logic [TASKS-1:0]      live_mask;
    logic [TASKS-1:0]      prio_ok;
    logic [TASKS-1:0]      eligible;
    logic [PRIO_W-1:0]     prio       [TASKS];
    logic [TASKS-1:0]      level_mask;
    logic                  level_found;
    logic [TASKS-1:0]      pick_onehot;
    logic [TASK_IDX_W-1:0] pick_idx;
    logic                  pick_found;
    logic [TASKS-1:0]      rest_mask;
    logic                  id_in_range;
    logic                  idle_valid;
    logic [TASK_IDX_W-1:0] acc_idx;
    logic [STAT_W-1:0]     idle_runs;
    logic [STAT_W-1:0]     idle_diff;
    logic [PROD_W-1:0]     load_prod;
    logic [LOAD_W-1:0]     load_quot;

    assign count_live = (task_count_reg > TASK_CNT_W'(TASKS)) ? TASK_CNT_W'(TASKS)
                                                              : task_count_reg;
    assign id_in_range = id_reg < count_live;
    assign idle_valid  = idle_task_reg < count_live;

    always_comb
    begin
        for (int n = 0; n < TASKS; n++)
        begin
            prio[n]      = task_prio_reg[PRIO_W*n +: PRIO_W];
            live_mask[n] = TASK_CNT_W'(n) < count_live;
            prio_ok[n]   = prio[n] <= PRIO_W'(TOP_PRIORITY);
        end
    end

    assign eligible = expired_mask & enabled_reg & ~suspended_reg & live_mask & prio_ok;

    // Highest priority level with a pending task, then the lowest index in it.
    always_comb
    begin
        level_mask  = '0;
        level_found = 1'b0;
        for (int p = TOP_PRIORITY; p >= 0; p--)
        begin
            if (!level_found)
            begin
                for (int n = 0; n < TASKS; n++)
                begin
                    level_mask[n] = pending_reg[n] && (prio[n] == PRIO_W'(p));
                end
                level_found = |level_mask;
            end
        end
        pick_idx    = '0;
        pick_onehot = '0;
        for (int n = TASKS - 1; n >= 0; n--)
        begin
            if (level_mask[n])
            begin
                pick_idx    = TASK_IDX_W'(n);
                pick_onehot = TASKS'(1) << n;
            end
        end
    end

    assign pick_found = |pending_reg;
    assign rest_mask  = pending_reg & ~pick_onehot;

    always_comb
    begin
        if (op_reg == CMD_SCAN)
        begin
            acc_idx = pick_idx;
        end
        else if (op_reg == CMD_LOAD)
        begin
            acc_idx = idle_task_reg[TASK_IDX_W-1:0];
        end
        else
        begin
            acc_idx = id_reg[TASK_IDX_W-1:0];
        end
    end

    assign idle_runs = idle_valid ? runs_reg[acc_idx] : '0;
    assign idle_diff = idle_runs - prev_idle_reg;
    assign load_prod = diff_reg * RECIP_W'(RECIP);
    assign load_quot = load_prod[RECIP_SHIFT +: LOAD_W];

    assign stat.out_free  = !out_valid_reg || out_ready;
    assign stat.final_res = (op_reg != CMD_SCAN) || !pick_found || (rest_mask == '0);

    always_comb
    begin
        enabled_next   = enabled_reg;
        suspended_next = suspended_reg;
        runs_next      = runs_reg;
        sums_next      = sums_reg;
        maxs_next      = maxs_reg;
        prev_idle_next = prev_idle_reg;
        load_next      = load_reg;
        op_next        = op_reg;
        id_next        = id_reg;
        cycles_next    = cycles_reg;
        pending_next   = pending_reg;
        diff_next      = diff_reg;
        dv_next        = dv_reg;
        idx_next       = idx_reg;
        last_next      = last_reg;
        stat_next      = stat_reg;
        run_next       = run_reg;
        tot_next       = tot_reg;
        max_next       = max_reg;
        load_o_next    = load_o_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;

        if (ctrl.capture)
        begin
            op_next      = cmd_t'(command);
            id_next      = task_id;
            cycles_next  = exec_cycles;
            pending_next = eligible;
        end

        if (ctrl.prep && op_reg == CMD_LOAD)
        begin
            prev_idle_next = idle_runs;
            diff_next      = (idle_diff > STAT_W'(IDLE_CAP)) ? DIFF_W'(IDLE_CAP)
                                                             : idle_diff[DIFF_W-1:0];
        end

        if (ctrl.emit)
        begin
            out_valid_next = 1'b1;
            dv_next        = 1'b0;
            idx_next       = '0;
            last_next      = 1'b1;
            stat_next      = 1'b0;
            run_next       = '0;
            tot_next       = '0;
            max_next       = '0;
            load_o_next    = load_reg;
            if (op_reg == CMD_SCAN)
            begin
                if (pick_found)
                begin
                    runs_next[acc_idx] = runs_reg[acc_idx] + 1'b1;
                    pending_next       = rest_mask;
                    dv_next            = 1'b1;
                    idx_next           = acc_idx;
                    last_next          = rest_mask == '0;
                    run_next           = runs_reg[acc_idx] + 1'b1;
                    tot_next           = sums_reg[acc_idx];
                    max_next           = maxs_reg[acc_idx];
                end
            end
            else if (op_reg == CMD_LOAD)
            begin
                load_next   = LOAD_W'(FULL_PERCENT) - load_quot;
                load_o_next = LOAD_W'(FULL_PERCENT) - load_quot;
            end
            else if (!id_in_range)
            begin
                idx_next  = id_reg[TASK_IDX_W-1:0];
                stat_next = 1'b1;
            end
            else
            begin
                idx_next = acc_idx;
                run_next = runs_reg[acc_idx];
                tot_next = sums_reg[acc_idx];
                max_next = maxs_reg[acc_idx];
                case (op_reg)
                    CMD_DISABLE:
                    begin
                        enabled_next[acc_idx]   = 1'b0;
                        suspended_next[acc_idx] = 1'b0;
                    end
                    CMD_ENABLE:
                    begin
                        enabled_next[acc_idx]   = 1'b1;
                        suspended_next[acc_idx] = 1'b0;
                    end
                    CMD_SUSPEND:
                    begin
                        suspended_next[acc_idx] = 1'b1;
                    end
                    CMD_RESUME:
                    begin
                        suspended_next[acc_idx] = 1'b0;
                    end
                    CMD_REPORT:
                    begin
                        sums_next[acc_idx] = sums_reg[acc_idx] + cycles_reg;
                        tot_next           = sums_reg[acc_idx] + cycles_reg;
                        if (cycles_reg > maxs_reg[acc_idx])
                        begin
                            maxs_next[acc_idx] = cycles_reg;
                            max_next           = cycles_reg;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Configuration and task state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            task_count_reg <= '0;
            task_prio_reg  <= '0;
            idle_task_reg  <= TASK_CNT_W'(TASKS);
            enabled_reg    <= '1;
            suspended_reg  <= '0;
            for (int n = 0; n < TASKS; n++)
            begin
                runs_reg[n] <= '0;
                sums_reg[n] <= '0;
                maxs_reg[n] <= '0;
            end
            prev_idle_reg  <= '0;
            load_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    CFG_TASK_COUNT: task_count_reg <= cfg_data[TASK_CNT_W-1:0];
                    CFG_PRIORITIES: task_prio_reg  <= cfg_data[PRIO_BITS-1:0];
                    CFG_IDLE_TASK:  idle_task_reg  <= cfg_data[TASK_CNT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            enabled_reg   <= enabled_next;
            suspended_reg <= suspended_next;
            runs_reg      <= runs_next;
            sums_reg      <= sums_next;
            maxs_reg      <= maxs_next;
            prev_idle_reg <= prev_idle_next;
            load_reg      <= load_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and result payload.
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        id_reg      <= id_next;
        cycles_reg  <= cycles_next;
        pending_reg <= pending_next;
        diff_reg    <= diff_next;
        dv_reg      <= dv_next;
        idx_reg     <= idx_next;
        last_reg    <= last_next;
        stat_reg    <= stat_next;
        run_reg     <= run_next;
        tot_reg     <= tot_next;
        max_reg     <= max_next;
        load_o_reg  <= load_o_next;
    end

    assign out_valid      = out_valid_reg;
    assign dispatch_valid = dv_reg;
    assign task_index     = idx_reg;
    assign last           = last_reg;
    assign status         = stat_reg;
    assign run_count      = run_reg;
    assign total_cycles   = tot_reg;
    assign max_cycles     = max_reg;
    assign cpu_load       = load_o_reg;

endmodule

// ===== hdl/fixed_priority_task_dispatcher.sv =====
// Top level of the fixed-priority task dispatcher: controller and datapath.
`timescale 1ns / 1ps

// The dispatcher keeps enabled, suspended and statistics state for up to eight
// tasks and takes one command word at a time on the input channel. A scan word
// returns one result word per dispatched task, priority 5 down to 0 and lower
// index first within a priority, with last set on the final one; a scan that
// finds nothing returns a single word with dispatch_valid low. Every other
// command returns exactly one word. An item is accepted, passes a preparation
// step and then produces its result words, each only while the output
// register can take it; the scan pace is set by the single priority picker,
// which selects one task per cycle when the output side does not stall. A new
// word is accepted only after the previous item has produced its last result
// word, while that word may still sit in the output register waiting to be
// taken. Configuration writes take effect at the clock edge where
// cfg_write_en is high and are meant for idle periods.
module fixed_priority_task_dispatcher
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write_en,
    input  logic [fptd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fptd_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [2:0]                           command,
    input  logic [3:0]                           task_id,
    input  logic [fptd_pkg::TASKS-1:0]           expired_mask,
    input  logic [fptd_pkg::STAT_W-1:0]          exec_cycles,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 dispatch_valid,
    output logic [fptd_pkg::TASK_IDX_W-1:0]      task_index,
    output logic                                 last,
    output logic                                 status,
    output logic [fptd_pkg::STAT_W-1:0]          run_count,
    output logic [fptd_pkg::STAT_W-1:0]          total_cycles,
    output logic [fptd_pkg::STAT_W-1:0]          max_cycles,
    output logic [fptd_pkg::LOAD_W-1:0]          cpu_load
);
    import fptd_pkg::*;

    // The controller sequences capture, preparation and result steps; the
    // datapath reports whether the output register is free and whether the
    // word it is about to produce closes the current item.
    dp_ctrl_t ctrl;
    dp_stat_t stat;

    fptd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    fptd_dp u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .stat           (stat),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .command        (command),
        .task_id        (task_id),
        .expired_mask   (expired_mask),
        .exec_cycles    (exec_cycles),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .dispatch_valid (dispatch_valid),
        .task_index     (task_index),
        .last           (last),
        .status         (status),
        .run_count      (run_count),
        .total_cycles   (total_cycles),
        .max_cycles     (max_cycles),
        .cpu_load       (cpu_load)
    );

endmodule

// ===== bench/fixed_priority_task_dispatcher_tb.sv =====
// Self-checking testbench for the fixed-priority task dispatcher.
`timescale 1ns / 1ps

// The bench drives command words into the dispatcher over the input channel and
// takes result words from the output channel, each side with random idle gaps
// and stretches without any. Every accepted command word runs through a
// behavioral scheduler kept inside the bench (flags, statistics, load and the
// three configuration registers), which queues the result words the dispatcher
// owes for it. Each result word taken from the block is compared with the
// oldest queued word. A short directed table comes first, then several random
// phases, each under its own register setting.
module fixed_priority_task_dispatcher_tb;

    import fptd_pkg::*;

    // One result word, in the order of the output ports.
    typedef struct packed {
        logic                  dv;
        logic [TASK_IDX_W-1:0] idx;
        logic                  last;
        logic                  status;
        logic [STAT_W-1:0]     runs;
        logic [STAT_W-1:0]     total;
        logic [STAT_W-1:0]     peak;
        logic [LOAD_W-1:0]     load;
    } result_word_t;

    // One row of the directed table: either a register write or a command word,
    // the latter optionally with its result written out by hand.
    typedef struct {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  reg_sel;
        logic [CFG_DATA_W-1:0] reg_val;
        cmd_t                  op;
        logic [3:0]            id;
        logic [TASKS-1:0]      mask;
        logic [STAT_W-1:0]     cyc;
        logic                  known;
        result_word_t          golden;
    } plan_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [2:0]            command = CMD_SCAN;
    logic [3:0]            task_id = '0;
    logic [TASKS-1:0]      expired_mask = '0;
    logic [STAT_W-1:0]     exec_cycles = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  dispatch_valid;
    logic [TASK_IDX_W-1:0] task_index;
    logic                  last;
    logic                  status;
    logic [STAT_W-1:0]     run_count;
    logic [STAT_W-1:0]     total_cycles;
    logic [STAT_W-1:0]     max_cycles;
    logic [LOAD_W-1:0]     cpu_load;

    // Scheduler state as the bench believes it to be, starting from reset.
    logic [TASK_CNT_W-1:0] cfg_count = '0;
    logic [CFG_DATA_W-1:0] cfg_prio = '0;
    logic [TASK_CNT_W-1:0] cfg_idle = 4'd8;
    logic [TASKS-1:0]      task_enabled = '1;
    logic [TASKS-1:0]      task_held = '0;
    logic [STAT_W-1:0]     task_runs [TASKS] = '{default: '0};
    logic [STAT_W-1:0]     task_cycle_sum [TASKS] = '{default: '0};
    logic [STAT_W-1:0]     task_cycle_peak [TASKS] = '{default: '0};
    logic [STAT_W-1:0]     idle_runs_seen = '0;
    logic [LOAD_W-1:0]     load_pct = '0;

    // Result words owed by the dispatcher, oldest first.
    result_word_t awaited[$];
    plan_row_t    plan[$];

    // When set, the matching side runs without idle gaps for a while.
    logic send_calm = 1'b0;
    logic take_calm = 1'b0;

    int words_sent = 0;
    int writes_done = 0;
    int words_checked = 0;
    int dispatches_seen = 0;
    int failures = 0;

    fixed_priority_task_dispatcher u_dut (.*);

    always #5 clk = ~clk;

    // Builds the stats part of a result word from the current scheduler state.
    // The word is marked last; a scan clears the flag on all but its final word.
    function automatic result_word_t stats_word(logic dv, logic [3:0] id, logic has_task,
                                                logic err);
        result_word_t w;
        w = '0;
        w.dv = dv;
        w.idx = id[TASK_IDX_W-1:0];
        w.last = 1'b1;
        w.status = err;
        w.load = load_pct;
        if (has_task)
        begin
            w.runs = task_runs[id[TASK_IDX_W-1:0]];
            w.total = task_cycle_sum[id[TASK_IDX_W-1:0]];
            w.peak = task_cycle_peak[id[TASK_IDX_W-1:0]];
        end
        return w;
    endfunction

    // Applies one accepted command word to the scheduler state and queues the
    // result words it must produce.
    function automatic void forecast(cmd_t op, logic [3:0] id, logic [TASKS-1:0] mask,
                                     logic [STAT_W-1:0] cyc);
        int live;
        int picked[$];
        logic [STAT_W-1:0] idle_now;
        logic [STAT_W-1:0] diff;
        result_word_t w;
        live = (cfg_count > TASKS) ? TASKS : int'(cfg_count);
        if (op == CMD_SCAN)
        begin
            // Highest dispatchable priority first, lower index first within one.
            // Priorities 6 and 7 are never reached by the loop.
            for (int p = TOP_PRIORITY; p >= 0; p--)
                for (int n = 0; n < live; n++)
                    if (mask[n] && task_enabled[n] && !task_held[n] &&
                        cfg_prio[PRIO_W*n +: PRIO_W] == p)
                        picked.push_back(n);
            if (picked.size() == 0)
                awaited.push_back(stats_word(1'b0, 4'd0, 1'b0, 1'b0));
            foreach (picked[i])
            begin
                task_runs[picked[i]]++;
                w = stats_word(1'b1, 4'(picked[i]), 1'b1, 1'b0);
                w.last = (i == picked.size() - 1);
                awaited.push_back(w);
            end
        end
        else if (op == CMD_LOAD)
        begin
            // Idle runs since the last update, clamped; a missing idle task counts
            // as zero runs, so the difference can wrap and then clamps to full.
            idle_now = (cfg_idle < live) ? task_runs[cfg_idle] : '0;
            diff = idle_now - idle_runs_seen;
            idle_runs_seen = idle_now;
            if (diff > IDLE_CAP)
                diff = IDLE_CAP;
            load_pct = LOAD_W'(FULL_PERCENT - (diff * FULL_PERCENT) / IDLE_CAP);
            awaited.push_back(stats_word(1'b0, 4'd0, 1'b0, 1'b0));
        end
        else if (id >= live)
        begin
            awaited.push_back(stats_word(1'b0, id, 1'b0, 1'b1));
        end
        else
        begin
            case (op)
                CMD_DISABLE:
                begin
                    task_enabled[id] = 1'b0;
                    task_held[id] = 1'b0;
                end
                CMD_ENABLE:
                begin
                    task_enabled[id] = 1'b1;
                    task_held[id] = 1'b0;
                end
                CMD_SUSPEND: task_held[id] = 1'b1;
                CMD_RESUME:  task_held[id] = 1'b0;
                CMD_REPORT:
                begin
                    task_cycle_sum[id] += cyc;
                    if (cyc > task_cycle_peak[id])
                        task_cycle_peak[id] = cyc;
                end
                default: ;
            endcase
            awaited.push_back(stats_word(1'b0, id, 1'b1, 1'b0));
        end
    endfunction

    function automatic result_word_t fixed_word(logic [TASK_IDX_W-1:0] idx, logic err,
                                                logic [STAT_W-1:0] total,
                                                logic [STAT_W-1:0] peak,
                                                logic [LOAD_W-1:0] load);
        result_word_t w;
        w = '0;
        w.idx = idx;
        w.last = 1'b1;
        w.status = err;
        w.total = total;
        w.peak = peak;
        w.load = load;
        return w;
    endfunction

    function automatic void plan_word(cmd_t op, logic [3:0] id, logic [TASKS-1:0] mask,
                                      logic [STAT_W-1:0] cyc, logic known = 1'b0,
                                      result_word_t golden = '0);
        plan_row_t r;
        r.is_cfg = 1'b0;
        r.reg_sel = CFG_TASK_COUNT;
        r.reg_val = '0;
        r.op = op;
        r.id = id;
        r.mask = mask;
        r.cyc = cyc;
        r.known = known;
        r.golden = golden;
        plan.push_back(r);
    endfunction

    function automatic void plan_cfg(logic [CFG_IDX_W-1:0] sel, logic [CFG_DATA_W-1:0] val);
        plan_row_t r;
        r.is_cfg = 1'b1;
        r.reg_sel = sel;
        r.reg_val = val;
        r.op = CMD_SCAN;
        r.id = '0;
        r.mask = '0;
        r.cyc = '0;
        r.known = 1'b0;
        r.golden = '0;
        plan.push_back(r);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_prio(int top);
        logic [CFG_DATA_W-1:0] v;
        v = '0;
        for (int n = 0; n < TASKS; n++)
            v[PRIO_W*n +: PRIO_W] = PRIO_W'($urandom_range(0, top));
        return v;
    endfunction

    // Stops offering words and waits until every owed result word has been taken.
    task automatic settle();
        if (in_valid)
            in_valid <= 1'b0;
        while (awaited.size() != 0)
            @(posedge clk);
    endtask

    // Register writes happen only with the dispatcher idle.
    task automatic write_reg(logic [CFG_IDX_W-1:0] sel, logic [CFG_DATA_W-1:0] val);
        settle();
        cfg_write_en <= 1'b1;
        cfg_index <= sel;
        cfg_data <= val;
        @(posedge clk);
        case (sel)
            CFG_TASK_COUNT: cfg_count = val[TASK_CNT_W-1:0];
            CFG_PRIORITIES: cfg_prio = val;
            CFG_IDLE_TASK:  cfg_idle = val[TASK_CNT_W-1:0];
            default: ;
        endcase
        cfg_write_en <= 1'b0;
        @(posedge clk);
        writes_done++;
    endtask

    // Offers one command word after a random gap and holds it until accepted.
    // When it is entered in the time step of the previous acceptance, the
    // valid line still gets exactly one assignment there.
    task automatic send_word(cmd_t op, logic [3:0] id, logic [TASKS-1:0] mask,
                             logic [STAT_W-1:0] cyc, logic known = 1'b0,
                             result_word_t golden = '0);
        int gap;
        gap = send_calm ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            if (in_valid)
                in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= op;
        task_id <= id;
        expired_mask <= mask;
        exec_cycles <= cyc;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        forecast(op, id, mask, cyc);
        // Hand-written rows always owe a single word; it replaces the computed one.
        if (known)
        begin
            void'(awaited.pop_back());
            awaited.push_back(golden);
        end
        words_sent++;
    endtask

    // Draws one random command word. Most task ids land on registered tasks and
    // the idle task's expiry bit is set often, so that load updates see real
    // idle activity.
    task automatic random_word(int scan_share, int load_share);
        int roll;
        int live;
        cmd_t op;
        logic [3:0] id;
        logic [TASKS-1:0] mask;
        logic [STAT_W-1:0] cyc;
        live = (cfg_count > TASKS) ? TASKS : int'(cfg_count);
        roll = $urandom_range(0, 99);
        if (roll < scan_share)
            op = CMD_SCAN;
        else if (roll < scan_share + load_share)
            op = CMD_LOAD;
        else
        begin
            case ($urandom_range(0, 5))
                0:       op = CMD_DISABLE;
                1:       op = CMD_ENABLE;
                2:       op = CMD_SUSPEND;
                3:       op = CMD_RESUME;
                4:       op = CMD_REPORT;
                default: op = CMD_STATS;
            endcase
        end
        if (live > 0 && $urandom_range(0, 99) < 85)
            id = 4'($urandom_range(0, live - 1));
        else
            id = 4'($urandom_range(0, 15));
        mask = ($urandom_range(0, 4) == 0) ? '1 : TASKS'($urandom);
        if (cfg_idle < TASKS && $urandom_range(0, 1) == 1)
            mask[cfg_idle[TASK_IDX_W-1:0]] = 1'b1;
        case ($urandom_range(0, 7))
            0:       cyc = '1;
            1:       cyc = '0;
            2:       cyc = STAT_W'($urandom_range(0, 1000));
            default: cyc = $urandom;
        endcase
        if (words_sent % 25 == 0)
            send_calm = ($urandom_range(0, 9) < 3);
        // Now and then the sender holds back until the dispatcher has drained.
        if ($urandom_range(0, 24) == 0)
            settle();
        send_word(op, id, mask, cyc);
    endtask

    // Result side: random stalls per word, compare against the oldest owed word.
    initial
    begin : result_sink
        int stall;
        result_word_t got;
        result_word_t want;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (words_checked % 25 == 0)
                take_calm = ($urandom_range(0, 9) < 3);
            stall = take_calm ? 0 : $urandom_range(0, 13);
            if (stall > 0)
            begin
                if (out_ready)
                    out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            if (!out_ready)
                out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            got = {dispatch_valid, task_index, last, status, run_count, total_cycles,
                   max_cycles, cpu_load};
            if (awaited.size() == 0)
            begin
                want = '0;
                failures++;
                if (failures <= 10)
                    $display("%0t: result word with nothing owed: dv=%0b idx=%0d last=%0b",
                             $time, got.dv, got.idx, got.last);
            end
            else
            begin
                want = awaited.pop_front();
                if (got !== want)
                begin
                    failures++;
                    if (failures <= 10)
                    begin
                        $display("%0t: mismatch on result word %0d", $time, words_checked);
                        $display("  want dv=%0b idx=%0d last=%0b st=%0b",
                                 want.dv, want.idx, want.last, want.status);
                        $display("       runs=%0d total=%0d max=%0d load=%0d",
                                 want.runs, want.total, want.peak, want.load);
                        $display("  got  dv=%0b idx=%0d last=%0b st=%0b",
                                 got.dv, got.idx, got.last, got.status);
                        $display("       runs=%0d total=%0d max=%0d load=%0d",
                                 got.runs, got.total, got.peak, got.load);
                    end
                end
            end
            words_checked++;
            if (got.dv === 1'b1)
                dispatches_seen++;
        end
    end

    initial
    begin : stimulus
        logic [TASK_CNT_W-1:0] n_cnt;
        logic [TASK_CNT_W-1:0] n_idle;
        logic [CFG_DATA_W-1:0] n_prio;
        int items;

        // Straight out of reset no task is registered, so every addressed
        // command is out of range, a scan is empty and the load reads full.
        plan_word(CMD_STATS, 4'd0, 8'h00, 32'd0, 1'b1,
                  fixed_word(3'd0, 1'b1, 32'd0, 32'd0, 7'd0));
        plan_word(CMD_SCAN, 4'd0, 8'hFF, 32'd0, 1'b1,
                  fixed_word(3'd0, 1'b0, 32'd0, 32'd0, 7'd0));
        plan_word(CMD_LOAD, 4'd9, 8'h00, 32'd0, 1'b1,
                  fixed_word(3'd0, 1'b0, 32'd0, 32'd0, 7'd100));
        plan_word(CMD_REPORT, 4'd15, 8'hFF, 32'hFFFF_FFFF, 1'b1,
                  fixed_word(3'd7, 1'b1, 32'd0, 32'd0, 7'd100));
        // A count above the task limit behaves as eight tasks. Priorities, task 7
        // down to 0, are 4 1 7 3 6 0 5 5: tasks 3 and 5 sit above five.
        plan_cfg(CFG_TASK_COUNT, 24'd15);
        plan_cfg(CFG_PRIORITIES, 24'o41736055);
        plan_cfg(CFG_IDLE_TASK, 24'd2);
        plan_word(CMD_SCAN, 4'd0, 8'hFF, 32'd0);
        plan_word(CMD_SCAN, 4'd0, 8'h00, 32'd0, 1'b1,
                  fixed_word(3'd0, 1'b0, 32'd0, 32'd0, 7'd100));
        plan_word(CMD_SUSPEND, 4'd1, 8'h00, 32'd0);
        plan_word(CMD_DISABLE, 4'd4, 8'h00, 32'd0);
        plan_word(CMD_SCAN, 4'd0, 8'hFF, 32'd0);
        plan_word(CMD_ENABLE, 4'd4, 8'h00, 32'd0);
        plan_word(CMD_RESUME, 4'd1, 8'h00, 32'd0);
        // Enable also lifts a suspension.
        plan_word(CMD_SUSPEND, 4'd6, 8'h00, 32'd0);
        plan_word(CMD_ENABLE, 4'd6, 8'h00, 32'd0);
        plan_word(CMD_SCAN, 4'd0, 8'h55, 32'd0);
        // The cycle sum wraps to zero while the maximum keeps the largest value.
        plan_word(CMD_REPORT, 4'd3, 8'h00, 32'hFFFF_FFFF);
        plan_word(CMD_REPORT, 4'd3, 8'h00, 32'd1, 1'b1,
                  fixed_word(3'd3, 1'b0, 32'd0, 32'hFFFF_FFFF, 7'd100));
        plan_word(CMD_REPORT, 4'd7, 8'hFF, 32'd0);
        plan_word(CMD_STATS, 4'd8, 8'hFF, 32'd0, 1'b1,
                  fixed_word(3'd0, 1'b1, 32'd0, 32'd0, 7'd100));
        plan_word(CMD_STATS, 4'd0, 8'h00, 32'd0);
        plan_word(CMD_SCAN, 4'd0, 8'hAA, 32'd0);
        plan_word(CMD_LOAD, 4'd5, 8'h00, 32'd0);
        // With no idle task the idle runs drop to zero: the difference wraps,
        // clamps, and the load reads zero; the next update reads full again.
        plan_cfg(CFG_IDLE_TASK, 24'd8);
        plan_word(CMD_LOAD, 4'd0, 8'h00, 32'd0);
        plan_word(CMD_LOAD, 4'd0, 8'h00, 32'd0);
        // Every task above priority five: a full scan dispatches nothing.
        plan_cfg(CFG_PRIORITIES, 24'hFF_FFFF);
        plan_word(CMD_SCAN, 4'd0, 8'hFF, 32'd0, 1'b1,
                  fixed_word(3'd0, 1'b0, 32'd0, 32'd0, 7'd100));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                write_reg(plan[i].reg_sel, plan[i].reg_val);
            else
                send_word(plan[i].op, plan[i].id, plan[i].mask, plan[i].cyc,
                          plan[i].known, plan[i].golden);
        end

        // Random phases. The first three pin the register extremes; phase 3 is a
        // long scan-heavy run between two load updates so the idle task gathers
        // enough runs to move the load off full; the rest are fully random.
        for (int ph = 0; ph < 8; ph++)
        begin
            items = 35;
            case (ph)
                0:
                begin
                    n_cnt = 4'd8;
                    n_prio = rand_prio(TOP_PRIORITY);
                    n_idle = 4'($urandom_range(0, TASKS - 1));
                    items = 40;
                end
                1:
                begin
                    n_cnt = 4'd15;
                    n_prio = '1;
                    n_idle = 4'd8;
                    items = 30;
                end
                2:
                begin
                    n_cnt = 4'd0;
                    n_prio = '0;
                    n_idle = 4'd0;
                    items = 30;
                end
                3:
                begin
                    n_cnt = 4'd8;
                    n_prio = rand_prio(TOP_PRIORITY);
                    n_idle = 4'($urandom_range(0, TASKS - 1));
                end
                default:
                begin
                    n_cnt = 4'($urandom_range(1, 15));
                    n_prio = rand_prio(7);
                    n_idle = 4'($urandom_range(0, 15));
                end
            endcase
            // Bits above the register width are don't-care and get random values.
            write_reg(CFG_TASK_COUNT, {20'($urandom), n_cnt});
            write_reg(CFG_PRIORITIES, n_prio);
            write_reg(CFG_IDLE_TASK, {20'($urandom), n_idle});
            if (ph == 3)
            begin
                send_word(CMD_ENABLE, n_idle, '0, '0);
                send_word(CMD_LOAD, 4'($urandom), TASKS'($urandom), $urandom);
                repeat (100) random_word(85, 0);
                send_word(CMD_LOAD, 4'($urandom), TASKS'($urandom), $urandom);
            end
            else
            begin
                repeat (items) random_word(40, 10);
            end
        end

        settle();
        // The last word may still be in flight inside the block; give it room.
        repeat (20) @(posedge clk);
        $display("Run covered %0d command words under %0d register writes,", words_sent,
                 writes_done);
        $display("with %0d result words checked, %0d of them task dispatches.",
                 words_checked, dispatches_seen);
        if (failures == 0 && awaited.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin : watchdog
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
